>>> rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, field widths, codes and decode functions of the tuner PLL
// word sequencer.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int FREQ_W   = 22;
    localparam int RATE_W   = 26;
    localparam int ADDR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int MSG_W    = 2;
    localparam int DIV_W    = 13;
    localparam int CODE_W   = 4;
    localparam int BAND_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [MSG_W-1:0] MSG_FIRST   = 2'd0;
    localparam logic [MSG_W-1:0] MSG_TRIGGER = 2'd1;
    localparam logic [MSG_W-1:0] MSG_FINAL   = 2'd2;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_CONTROL_BASE   = 1'b1;

    localparam logic [BYTE_W-1:0] CONTROL_BASE_RESET = 8'hE1;
    localparam logic [BYTE_W-1:0] CONTROL_KEEP_MASK  = 8'hE3;
    localparam logic [BYTE_W-1:0] TM_BIT             = 8'h04;
    localparam logic [BYTE_W-1:0] R3_FIRST_MASK      = 8'hF3;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [BYTE_W-1:0] control_base;
    } tps_cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0]  divider;
        logic [BYTE_W-1:0] r3;
        logic              pd5;
        logic              pd4;
    } tps_job_t;

    function automatic logic [CODE_W-1:0] lpf_code(input logic [RATE_W-1:0] rate);
        logic [CODE_W-1:0] code;
        if (rate >= 26'd39_000_000)      code = 4'd13;
        else if (rate >= 26'd35_000_000) code = 4'd12;
        else if (rate >= 26'd30_000_000) code = 4'd11;
        else if (rate >= 26'd26_000_000) code = 4'd10;
        else if (rate >= 26'd23_000_000) code = 4'd9;
        else if (rate >= 26'd21_000_000) code = 4'd8;
        else if (rate >= 26'd19_000_000) code = 4'd7;
        else if (rate >= 26'd18_000_000) code = 4'd6;
        else if (rate >= 26'd17_000_000) code = 4'd5;
        else if (rate >= 26'd16_000_000) code = 4'd4;
        else                             code = 4'd3;
        return code;
    endfunction

    // Returns the VCO divider bit above the three band bits.
    function automatic logic [BAND_W:0] vco_select(input logic [FREQ_W-1:0] f);
        logic [BAND_W:0] sel;
        if (f < 22'd1_065_000)      sel = {1'b1, 3'd6};
        else if (f < 22'd1_170_000) sel = {1'b1, 3'd7};
        else if (f < 22'd1_300_000) sel = {1'b0, 3'd1};
        else if (f < 22'd1_445_000) sel = {1'b0, 3'd2};
        else if (f < 22'd1_607_000) sel = {1'b0, 3'd3};
        else if (f < 22'd1_778_000) sel = {1'b0, 3'd4};
        else if (f < 22'd1_942_000) sel = {1'b0, 3'd5};
        else                        sel = {1'b0, 3'd6};
        return sel;
    endfunction

endpackage

>>> rtl/tps_if.sv
// ----------------------------------------------------------------------------
// tps_req_if / tps_byte_if
// Valid/ready channels for tuning requests and for emitted bus bytes.
// ----------------------------------------------------------------------------
interface tps_req_if
    import tps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] freq_khz;
    logic [RATE_W-1:0] sym_rate;

    modport source (output valid, freq_khz, sym_rate, input ready);
    modport sink   (input valid, freq_khz, sym_rate, output ready);
endinterface

interface tps_byte_if
    import tps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0] data_byte;
    logic [MSG_W-1:0]  message_index;
    logic              message_end;
    logic              last;

    modport source (output valid, bus_address, data_byte, message_index, message_end, last,
                    input ready);
    modport sink   (input valid, bus_address, data_byte, message_index, message_end, last,
                    output ready);
endinterface

>>> rtl/tps_regs.sv
// ----------------------------------------------------------------------------
// tps_regs
// APB-style configuration registers: device address and control base.
// ----------------------------------------------------------------------------
module tps_regs
    import tps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output tps_cfg_t           cfg
);

    logic [ADDR_W-1:0] dev_addr_reg;
    logic [BYTE_W-1:0] ctrl_base_reg;
    logic              wr_en;
    logic              reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= '0;
            ctrl_base_reg <= CONTROL_BASE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg  <= pwdata[ADDR_W-1:0];
                REG_CONTROL_BASE:   ctrl_base_reg <= pwdata[BYTE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DEVICE_ADDRESS: prdata = {{(PDATA_W-ADDR_W){1'b0}}, dev_addr_reg};
            REG_CONTROL_BASE:   prdata = {{(PDATA_W-BYTE_W){1'b0}}, ctrl_base_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.device_address = dev_addr_reg;
    assign cfg.control_base   = ctrl_base_reg;

endmodule

>>> rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// Accepts requests and classifies them: PLL divider by reciprocal multiply
// with one correction step, VCO band and low-pass filter code.
// ----------------------------------------------------------------------------
module tps_front
    import tps_pkg::*;
#(
    parameter int PLL_STEP_KHZ = 500
)
(
    input  logic     clk,
    input  logic     rst_n,
    tps_req_if.sink  req,
    output logic     push,
    output tps_job_t push_job,
    input  logic     queue_full
);

    localparam logic [31:0]       RECIP = 32'((64'd1 << 32) / PLL_STEP_KHZ);
    localparam logic [FREQ_W-1:0] STEP  = FREQ_W'(PLL_STEP_KHZ);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [FREQ_W-1:0]      s1_freq_reg;
    logic [FREQ_W-1:0]      s1_quot_reg;
    logic [BYTE_W-1:0]      s1_r3_reg;
    logic [1:0]             s1_pd45_reg;
    logic [FREQ_W+31:0]     product;
    logic [BAND_W:0]        vco;
    logic [CODE_W-1:0]      code;
    logic [FREQ_W-1:0]      back_prod;
    logic [FREQ_W-1:0]      remainder;
    logic [FREQ_W-1:0]      quotient;
    logic                   accept;

    assign req.ready = !s1_valid_reg || !queue_full;
    assign accept    = req.valid && req.ready;
    assign push      = s1_valid_reg && !queue_full;

    assign product = {32'b0, req.freq_khz} * {{FREQ_W{1'b0}}, RECIP};
    assign vco     = vco_select(req.freq_khz);
    assign code    = lpf_code(req.sym_rate);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_freq_reg <= req.freq_khz;
            s1_quot_reg <= product[FREQ_W+31:32];
            s1_r3_reg   <= {vco[BAND_W-1:0], 1'b0, code[2], code[3], vco[BAND_W], 1'b0};
            s1_pd45_reg <= {code[0], code[1]};
        end
    end

    assign back_prod = s1_quot_reg * STEP;
    assign remainder = s1_freq_reg - back_prod;
    assign quotient  = (remainder >= STEP) ? s1_quot_reg + 1'b1 : s1_quot_reg;

    assign push_job.divider = quotient[DIV_W-1:0];
    assign push_job.r3      = s1_r3_reg;
    assign push_job.pd5     = s1_pd45_reg[1];
    assign push_job.pd4     = s1_pd45_reg[0];

endmodule

>>> rtl/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue
// Short first-in first-out queue of classified requests between the front
// and back parts.
// ----------------------------------------------------------------------------
module tps_queue
    import tps_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tps_job_t push_job,
    input  logic     pop,
    output tps_job_t head,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tps_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back
// Steps through the seven bytes of the three-message write sequence for the
// request at the head of the queue, one byte per cycle into an output register while rsp does not stall.
// ----------------------------------------------------------------------------
module tps_back
    import tps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tps_cfg_t  cfg,
    input  tps_job_t  head,
    input  logic      empty,
    output logic      pop,
    tps_byte_if.source rsp
);

    localparam logic [2:0] BYTE_DIV_HI    = 3'd0;
    localparam logic [2:0] BYTE_DIV_LO    = 3'd1;
    localparam logic [2:0] BYTE_CTRL      = 3'd2;
    localparam logic [2:0] BYTE_R3_FIRST  = 3'd3;
    localparam logic [2:0] BYTE_TRIGGER   = 3'd4;
    localparam logic [2:0] BYTE_CTRL_FULL = 3'd5;
    localparam logic [2:0] BYTE_R3_FINAL  = 3'd6;

    logic [2:0]        cnt_reg;
    logic [2:0]        cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [MSG_W-1:0]  msg_reg;
    logic              end_reg;
    logic              last_reg;
    logic              load;
    logic [BYTE_W-1:0] r2_base;
    logic [BYTE_W-1:0] data_sel;
    logic [MSG_W-1:0]  msg_sel;
    logic              end_sel;

    assign load    = !empty && (!out_valid_reg || rsp.ready);
    assign pop     = load && (cnt_reg == BYTE_R3_FINAL);
    assign r2_base = cfg.control_base & CONTROL_KEEP_MASK;

    always_comb
    begin
        unique case (cnt_reg)
            BYTE_DIV_HI:
            begin
                data_sel = {3'b0, head.divider[DIV_W-1:8]};
                msg_sel  = MSG_FIRST;
                end_sel  = 1'b0;
            end
            BYTE_DIV_LO:
            begin
                data_sel = head.divider[7:0];
                msg_sel  = MSG_FIRST;
                end_sel  = 1'b0;
            end
            BYTE_CTRL:
            begin
                data_sel = r2_base;
                msg_sel  = MSG_FIRST;
                end_sel  = 1'b0;
            end
            BYTE_R3_FIRST:
            begin
                data_sel = head.r3 & R3_FIRST_MASK;
                msg_sel  = MSG_FIRST;
                end_sel  = 1'b1;
            end
            BYTE_TRIGGER:
            begin
                data_sel = r2_base | TM_BIT;
                msg_sel  = MSG_TRIGGER;
                end_sel  = 1'b1;
            end
            BYTE_CTRL_FULL:
            begin
                data_sel = r2_base | TM_BIT | {3'b0, head.pd5, head.pd4, 3'b0};
                msg_sel  = MSG_FINAL;
                end_sel  = 1'b0;
            end
            default:
            begin
                data_sel = head.r3;
                msg_sel  = MSG_FINAL;
                end_sel  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            cnt_next       = (cnt_reg == BYTE_R3_FINAL) ? BYTE_DIV_HI : cnt_reg + 1'b1;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= BYTE_DIV_HI;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= cfg.device_address;
            data_reg <= data_sel;
            msg_reg  <= msg_sel;
            end_reg  <= end_sel;
            last_reg <= (cnt_reg == BYTE_R3_FINAL);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.bus_address   = addr_reg;
    assign rsp.data_byte     = data_reg;
    assign rsp.message_index = msg_reg;
    assign rsp.message_end   = end_reg;
    assign rsp.last          = last_reg;

endmodule

>>> rtl/tuner_pll_word_sequencer.sv
// ----------------------------------------------------------------------------
// tuner_pll_word_sequencer
// Turns a tuning request into the seven-byte tuner register write sequence.
// ----------------------------------------------------------------------------
// Usage:
// A request (freq_khz, sym_rate) enters on the req channel; each request
// yields seven bus bytes on the rsp channel, tagged with the device address,
// the message index, an end-of-message flag and a flag on the seventh byte.
// The device address and control base are written through the APB port, by the
// user only while no request is in flight; the block itself does not enforce it.
// The first byte of a request passes the divider stage register and the queue
// before the output register presents it. Bytes then follow one per cycle while
// rsp does not stall; the byte sequencer that drives the single output register
// sets the pace of a steady stream of requests, which wait in the queue meanwhile.
// The front part takes a new request every cycle until the queue fills, so a
// stall on rsp holds the output register and backs up into the queue before
// req.ready falls.
// Reset empties the pipeline and queue and restores the register defaults.
// ----------------------------------------------------------------------------
module tuner_pll_word_sequencer
    import tps_pkg::*;
#(
    parameter int PLL_STEP_KHZ = 500,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    tps_req_if.sink            req,
    tps_byte_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    tps_cfg_t cfg;
    tps_job_t push_job;
    tps_job_t head;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    tps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tps_front #(
        .PLL_STEP_KHZ (PLL_STEP_KHZ)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push       (push),
        .push_job   (push_job),
        .queue_full (full)
    );

    tps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    tps_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

>>> rtl/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks on the byte stream of the tuner PLL word sequencer.
// ----------------------------------------------------------------------------
module tps_checker
    import tps_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ADDR_W-1:0] rsp_bus_address,
    input logic [BYTE_W-1:0] rsp_data_byte,
    input logic [MSG_W-1:0]  rsp_message_index,
    input logic              rsp_message_end,
    input logic              rsp_last
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_bus_address, rsp_data_byte,
            rsp_message_index, rsp_message_end, rsp_last}))
        else $error("Stalled byte changed or was dropped.");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_last |-> rsp_message_end && rsp_message_index == MSG_FINAL)
        else $error("Final byte is not the end of the final message.");

    a_trigger_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_message_index == MSG_TRIGGER |-> rsp_message_end && !rsp_last)
        else $error("Trigger message is not a single byte.");

    a_trigger_then_final: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_message_index == MSG_TRIGGER ##1 rsp_valid
        |-> rsp_message_index == MSG_FINAL)
        else $error("Trigger byte not followed by the final message.");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_message_index == MSG_FIRST)
        else $error("New sequence does not start with the first message.");

endmodule

bind tuner_pll_word_sequencer tps_checker u_tps_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_bus_address   (rsp.bus_address),
    .rsp_data_byte     (rsp.data_byte),
    .rsp_message_index (rsp.message_index),
    .rsp_message_end   (rsp.message_end),
    .rsp_last          (rsp.last)
);
